[sv/ogi_pkg.sv]
// shared constants and codes for the occupancy grid inflate block
// no dependencies
`timescale 1ns / 1ps

package ogi_pkg;

	// field widths
	localparam int PT_W       = 24;
	localparam int HE_W       = 23;
	localparam int CS_W       = 20;
	localparam int GD_W       = 10;
	localparam int RADCFG_W   = 4;
	localparam int IDX_W      = 9;
	localparam int VAL_W      = 7;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 23;
	localparam int ACT_W      = 2;

	// default sizes
	localparam int DEF_MAX_WIDTH  = 512;
	localparam int DEF_MAX_HEIGHT = 512;
	localparam int DEF_MAX_RADIUS = 15;

	// action codes
	localparam logic [ACT_W-1:0] ACT_CLEAR   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_ADD     = 2'd1;
	localparam logic [ACT_W-1:0] ACT_INFLATE = 2'd2;
	localparam logic [ACT_W-1:0] ACT_READ    = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HALF_X  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_Y  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CELL    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INFLATE = 3'd5;

	// register reset values
	localparam logic [HE_W-1:0]     RST_HALF    = 23'd81920;
	localparam logic [CS_W-1:0]     RST_CELL    = 20'd410;
	localparam logic [GD_W-1:0]     RST_GRID    = 10'd400;
	localparam logic [RADCFG_W-1:0] RST_INFLATE = 4'd3;

	// value reported for an occupied cell
	localparam logic [VAL_W-1:0] OCC_VALUE = 7'd100;

endpackage

[sv/occupancy_grid_inflate.sv]
// Occupancy grid with disc inflation. A clear (and the pass that follows reset)
// writes every entry of both bitmaps, 2**(clog2(MAX_WIDTH)+clog2(MAX_HEIGHT))
// entries (262144 at the defaults), during which no item is taken. Adding a
// point runs the two bit-serial dividers (24 steps) side by side. A read goes
// through ST_READ and ST_READV. Inflate clears the inflated bitmap, then
// scans the raw cells in use, reading each in ST_SCAN_RD and testing it in
// ST_SCAN_CHK, and, for each occupied one, walks 2r+1 rows, narrowing the row
// span in ST_SPAN and writing its cells one at a time in ST_ROW through the
// single write port of the inflated memory. Depends on ogi_pkg, ogi_div, ogi_ram.
`timescale 1ns / 1ps

module occupancy_grid_inflate
	import ogi_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [ACT_W-1:0]      action,
	input  logic [PT_W-1:0]       point_x,
	input  logic [PT_W-1:0]       point_y,
	input  logic [IDX_W-1:0]      cell_col,
	input  logic [IDX_W-1:0]      cell_row,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [VAL_W-1:0]      cell_value,
	output logic                  point_in_grid,
	output logic                  done_res,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int RW   = $clog2(MAX_HEIGHT);
	localparam int AW   = CW + RW;
	localparam int WW   = ($clog2(MAX_WIDTH + 1) > GD_W) ? $clog2(MAX_WIDTH + 1) : GD_W;
	localparam int HW   = ($clog2(MAX_HEIGHT + 1) > GD_W) ? $clog2(MAX_HEIGHT + 1) : GD_W;
	localparam int RADW = $clog2(MAX_RADIUS + 1);
	localparam int RXW  = (RADW > RADCFG_W) ? RADW : RADCFG_W;
	localparam int SQW  = 2 * RADW + 1;
	localparam int XW   = WW + RADW;
	localparam int YW   = HW + RADW;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLR,
		ST_DIV,
		ST_SET,
		ST_INF_CLR,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_SPAN,
		ST_ROW,
		ST_READ,
		ST_READV,
		ST_DONE
	} state_t;

	state_t state_q;

	// configuration registers
	logic [HE_W-1:0]     half_x_q;
	logic [HE_W-1:0]     half_y_q;
	logic [CS_W-1:0]     cell_size_q;
	logic [GD_W-1:0]     grid_w_q;
	logic [GD_W-1:0]     grid_h_q;
	logic [RADCFG_W-1:0] infl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_x_q    <= RST_HALF;
			half_y_q    <= RST_HALF;
			cell_size_q <= RST_CELL;
			grid_w_q    <= RST_GRID;
			grid_h_q    <= RST_GRID;
			infl_q      <= RST_INFLATE;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_HALF_X:  half_x_q    <= cfg_wdata[HE_W-1:0];
				REG_HALF_Y:  half_y_q    <= cfg_wdata[HE_W-1:0];
				REG_CELL:    cell_size_q <= cfg_wdata[CS_W-1:0];
				REG_WIDTH:   grid_w_q    <= cfg_wdata[GD_W-1:0];
				REG_HEIGHT:  grid_h_q    <= cfg_wdata[GD_W-1:0];
				REG_INFLATE: infl_q      <= cfg_wdata[RADCFG_W-1:0];
				default: ;
			endcase
		end
	end

	// effective grid size and radius
	logic [WW-1:0]   eff_w;
	logic [HW-1:0]   eff_h;
	logic [RXW-1:0]  r_ext;
	logic [RADW-1:0] rad;

	always_comb begin
		eff_w = (WW'(grid_w_q) > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(grid_w_q);
		eff_h = (HW'(grid_h_q) > HW'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(grid_h_q);
		r_ext = (RXW'(infl_q) > RXW'(MAX_RADIUS)) ? RXW'(MAX_RADIUS) : RXW'(infl_q);
		rad   = r_ext[RADW-1:0];
	end

	// point offsets, sign shows a point below the low edge
	logic [PT_W:0] sum_x;
	logic [PT_W:0] sum_y;

	assign sum_x = {point_x[PT_W-1], point_x} + {2'b00, half_x_q};
	assign sum_y = {point_y[PT_W-1], point_y} + {2'b00, half_y_q};

	logic            accept;
	logic            div_start;
	logic            div_done_x;
	logic            div_done_y;
	logic [PT_W-1:0] quo_x;
	logic [PT_W-1:0] quo_y;

	assign accept    = in_valid && in_ready;
	assign div_start = accept && (action == ACT_ADD);

	ogi_div u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_x[PT_W-1:0]),
		.divisor  (cell_size_q),
		.done     (div_done_x),
		.quotient (quo_x)
	);

	ogi_div u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_y[PT_W-1:0]),
		.divisor  (cell_size_q),
		.done     (div_done_y),
		.quotient (quo_y)
	);

	// datapath registers
	logic [AW-1:0]   clr_addr_q;
	logic            neg_x_q;
	logic            neg_y_q;
	logic            cs_zero_q;
	logic            hit_q;
	logic [CW-1:0]   cx_q;
	logic [RW-1:0]   cy_q;
	logic [CW-1:0]   x_q;
	logic [RW-1:0]   y_q;
	logic [RADW-1:0] s_q;
	logic            dneg_q;
	logic [RADW-1:0] dmag_q;
	logic [RW-1:0]   ny_q;
	logic [CW-1:0]   col_q;
	logic [CW-1:0]   hi_q;
	logic [CW-1:0]   rcol_q;
	logic [RW-1:0]   rrow_q;
	logic            rd_ok_q;
	logic            occ_q;
	logic            out_valid_q;
	logic            out_occ_q;
	logic            out_hit_q;

	logic raw_rdata;
	logic inf_rdata;

	// input field extensions for the read action
	logic [WW-1:0] rcol_ext;
	logic [HW-1:0] rrow_ext;

	assign rcol_ext = WW'(cell_col);
	assign rrow_ext = HW'(cell_row);

	// disc span search and row clipping
	logic [SQW-1:0] dist_sq;
	logic [SQW-1:0] rad_sq;
	logic           span_wide;
	logic [YW-1:0]  y_ext;
	logic [YW-1:0]  m_ext;
	logic [YW-1:0]  y_up;
	logic [YW-1:0]  y_dn;
	logic           row_ok;
	logic [RW-1:0]  row_sel;
	logic [XW-1:0]  x_ext;
	logic [XW-1:0]  s_ext;
	logic [XW-1:0]  lo_c;
	logic [XW-1:0]  hi_raw;
	logic [XW-1:0]  w_last;
	logic [XW-1:0]  hi_c;
	logic           last_dy;
	logic           last_x;
	logic           last_y;

	always_comb begin
		dist_sq   = SQW'(s_q) * SQW'(s_q) + SQW'(dmag_q) * SQW'(dmag_q);
		rad_sq    = SQW'(rad) * SQW'(rad);
		span_wide = dist_sq > rad_sq;
		y_ext     = YW'(y_q);
		m_ext     = YW'(dmag_q);
		y_up      = y_ext + m_ext;
		y_dn      = y_ext - m_ext;
		row_ok    = dneg_q ? (y_ext >= m_ext) : (y_up < YW'(eff_h));
		row_sel   = dneg_q ? y_dn[RW-1:0] : y_up[RW-1:0];
		x_ext     = XW'(x_q);
		s_ext     = XW'(s_q);
		lo_c      = (x_ext >= s_ext) ? (x_ext - s_ext) : '0;
		hi_raw    = x_ext + s_ext;
		w_last    = XW'(eff_w) - 1'b1;
		hi_c      = (hi_raw > w_last) ? w_last : hi_raw;
		last_dy   = !dneg_q && (dmag_q == rad);
		last_x    = (WW'(x_q) == (eff_w - 1'b1));
		last_y    = (HW'(y_q) == (eff_h - 1'b1));
	end

	// add-point grid test from the quotients
	logic hit_x;
	logic hit_y;

	assign hit_x = !neg_x_q && !cs_zero_q && (quo_x < PT_W'(eff_w));
	assign hit_y = !neg_y_q && !cs_zero_q && (quo_y < PT_W'(eff_h));

	// sequencer and registered results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_INIT, ST_CLR, ST_INF_CLR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == {AW{1'b1}}) begin
						if (state_q == ST_INIT) begin
							state_q <= ST_IDLE;
						end else if (state_q == ST_CLR) begin
							state_q <= ST_DONE;
						end else if ((eff_w == '0) || (eff_h == '0)) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_SCAN_RD;
						end
					end
				end
				ST_IDLE: begin
					if (accept) begin
						occ_q      <= 1'b0;
						hit_q      <= 1'b0;
						clr_addr_q <= '0;
						x_q        <= '0;
						y_q        <= '0;
						case (action)
							ACT_CLEAR:   state_q <= ST_CLR;
							ACT_ADD: begin
								neg_x_q   <= sum_x[PT_W];
								neg_y_q   <= sum_y[PT_W];
								cs_zero_q <= (cell_size_q == '0);
								state_q   <= ST_DIV;
							end
							ACT_INFLATE: state_q <= ST_INF_CLR;
							ACT_READ: begin
								rcol_q  <= rcol_ext[CW-1:0];
								rrow_q  <= rrow_ext[RW-1:0];
								rd_ok_q <= (rcol_ext < eff_w) && (rrow_ext < eff_h);
								state_q <= ST_READ;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_DIV: begin
					if (div_done_x && div_done_y) begin
						hit_q   <= hit_x && hit_y;
						cx_q    <= quo_x[CW-1:0];
						cy_q    <= quo_y[RW-1:0];
						state_q <= ST_SET;
					end
				end
				ST_SET: state_q <= ST_DONE;
				ST_SCAN_RD: state_q <= ST_SCAN_CHK;
				ST_SCAN_CHK: begin
					if (raw_rdata) begin
						s_q     <= rad;
						dneg_q  <= (rad != '0);
						dmag_q  <= rad;
						state_q <= ST_SPAN;
					end else if (last_x) begin
						x_q <= '0;
						if (last_y) begin
							state_q <= ST_DONE;
						end else begin
							y_q     <= y_q + 1'b1;
							state_q <= ST_SCAN_RD;
						end
					end else begin
						x_q     <= x_q + 1'b1;
						state_q <= ST_SCAN_RD;
					end
				end
				ST_SPAN, ST_ROW: begin
					// next_dy: either narrow the span, start or step along a row, or move on
					if ((state_q == ST_SPAN) && span_wide) begin
						s_q <= s_q - 1'b1;
					end else if ((state_q == ST_SPAN) && row_ok) begin
						ny_q    <= row_sel;
						col_q   <= lo_c[CW-1:0];
						hi_q    <= hi_c[CW-1:0];
						state_q <= ST_ROW;
					end else if ((state_q == ST_ROW) && (col_q != hi_q)) begin
						col_q <= col_q + 1'b1;
					end else if (!last_dy) begin
						s_q <= rad;
						if (dneg_q && (dmag_q == RADW'(1))) begin
							dneg_q <= 1'b0;
							dmag_q <= '0;
						end else if (dneg_q) begin
							dmag_q <= dmag_q - 1'b1;
						end else begin
							dmag_q <= dmag_q + 1'b1;
						end
						state_q <= ST_SPAN;
					end else if (last_x) begin
						x_q <= '0;
						if (last_y) begin
							state_q <= ST_DONE;
						end else begin
							y_q     <= y_q + 1'b1;
							state_q <= ST_SCAN_RD;
						end
					end else begin
						x_q     <= x_q + 1'b1;
						state_q <= ST_SCAN_RD;
					end
				end
				ST_READ: state_q <= ST_READV;
				ST_READV: begin
					occ_q   <= rd_ok_q && inf_rdata;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_occ_q   <= occ_q;
						out_hit_q   <= hit_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// memory ports
	logic          sweep_both;
	logic          raw_we;
	logic [AW-1:0] raw_waddr;
	logic          inf_we;
	logic [AW-1:0] inf_waddr;

	always_comb begin
		sweep_both = (state_q == ST_INIT) || (state_q == ST_CLR);
		raw_we     = sweep_both || ((state_q == ST_SET) && hit_q);
		raw_waddr  = sweep_both ? clr_addr_q : {cy_q, cx_q};
		inf_we     = sweep_both || (state_q == ST_INF_CLR) || (state_q == ST_ROW);
		inf_waddr  = (state_q == ST_ROW) ? {ny_q, col_q} : clr_addr_q;
	end

	ogi_ram #(
		.AW (AW)
	) u_raw (
		.clk   (clk),
		.we    (raw_we),
		.waddr (raw_waddr),
		.wdata (state_q == ST_SET),
		.raddr ({y_q, x_q}),
		.rdata (raw_rdata)
	);

	ogi_ram #(
		.AW (AW)
	) u_inflated (
		.clk   (clk),
		.we    (inf_we),
		.waddr (inf_waddr),
		.wdata (state_q == ST_ROW),
		.raddr ({rrow_q, rcol_q}),
		.rdata (inf_rdata)
	);

	// outputs
	assign in_ready      = (state_q == ST_IDLE);
	assign out_valid     = out_valid_q;
	assign cell_value    = out_occ_q ? OCC_VALUE : '0;
	assign point_in_grid = out_hit_q;
	assign done_res      = 1'b1;

endmodule

[sv/ogi_div.sv]
// bit-serial restoring divider, one quotient bit per cycle
// depends on ogi_pkg
`timescale 1ns / 1ps

module ogi_div
	import ogi_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [PT_W-1:0] dividend,
	input  logic [CS_W-1:0] divisor,
	output logic            done,
	output logic [PT_W-1:0] quotient
);

	localparam int CNT_W = $clog2(PT_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [PT_W-1:0]  num_q;
	logic [CS_W-1:0]  rem_q;
	logic [CS_W-1:0]  den_q;
	logic [CS_W:0]    shifted;
	logic [CS_W:0]    trial;
	logic             fits;

	// trial subtract of the divisor from the shifted remainder
	always_comb begin
		shifted = {rem_q, num_q[PT_W-1]};
		trial   = shifted - {1'b0, den_q};
		fits    = shifted >= {1'b0, den_q};
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(PT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// datapath, quotient bits shift in where dividend bits leave
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? trial[CS_W-1:0] : shifted[CS_W-1:0];
			num_q <= {num_q[PT_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = num_q;

endmodule

[sv/ogi_ram.sv]
// single bit wide synchronous memory, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module ogi_ram #(
	parameter int AW = 18
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic          wdata,
	input  logic [AW-1:0] raddr,
	output logic          rdata
);

	logic mem [2**AW];
	logic rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
